@@ hw/rtl/lorv_pkg.sv @@
// ----------------------------------------------------------------------------
// lorv_pkg
// shared types and constants of the load option record validator
// ----------------------------------------------------------------------------
`default_nettype none

package lorv_pkg;

   // record layout
   localparam int PLL_LO_POS   = 4;    // file path list length, low byte
   localparam int PLL_HI_POS   = 5;    // file path list length, high byte
   localparam int DESC_START   = 6;    // first description byte
   localparam int MIN_RECORD   = 12;
   localparam int LIST_SLACK   = 10;
   localparam int NODE_MIN     = 4;    // device path node header size
   localparam int HDR_LAST_K   = 3;    // header bytes collected before length high byte

   localparam logic [7:0] END_TYPE    = 8'h7f;
   localparam logic [7:0] END_SUBTYPE = 8'hff;

   // result status codes
   localparam logic [1:0] ST_NOOPT = 2'd0;
   localparam logic [1:0] ST_OPT   = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   typedef enum logic [5:0] {
      PH_HEADER    = 6'b000001,
      PH_DESC      = 6'b000010,
      PH_DESC_TERM = 6'b000100,
      PH_NODE_HDR  = 6'b001000,
      PH_NODE_BODY = 6'b010000,
      PH_DONE      = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      V_PENDING = 2'd0,
      V_NOOPT   = 2'd1,
      V_OPT     = 2'd2,
      V_BAD     = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] total_size;
      logic        last_byte;
   } item_type;

   typedef struct packed {
      logic        fire;
      logic [1:0]  status;
      logic [15:0] opt_offset;
      logic [15:0] opt_size;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/lorv_parser.sv @@
// ----------------------------------------------------------------------------
// lorv_parser
// per-byte record state and the checks that run on each byte
// ----------------------------------------------------------------------------
`default_nettype none

module lorv_parser #(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step_en,
   input  lorv_pkg::item_type   item,
   output lorv_pkg::result_type result
);

   localparam int LW = LENGTH_WIDTH;
   // wide enough for the 16-bit list and node lengths at any record width
   localparam int LX = (LENGTH_WIDTH + 1 > 17) ? LENGTH_WIDTH + 1 : 17;
   localparam int WW = (LENGTH_WIDTH + 2 > 16) ? LENGTH_WIDTH + 2 : 16;

   lorv_pkg::phase_type   phase_ff, phase_in;
   lorv_pkg::verdict_type verdict_ff, verdict_in;
   logic [LW-1:0]         pos_ff, pos_in;
   logic [LW-1:0]         rs_ff, rs_in;
   logic [15:0]           pll_ff, pll_in;
   logic [LW-1:0]         desc_ff, desc_in;
   logic [LX-1:0]         pbs_ff, pbs_in;
   logic [23:0]           nh_ff, nh_in;
   logic [LW-1:0]         left_ff, left_in;

   logic [LX-1:0] limit;
   logic [LX-1:0] node_rem;
   logic [LX-1:0] walk_rem;
   logic [LX-1:0] count;
   logic [15:0]   node_len;
   logic          do_walk;
   logic [WW-1:0] off_w;
   logic [WW-1:0] size_w;

   always_comb begin
      phase_in   = phase_ff;
      verdict_in = verdict_ff;
      pos_in     = pos_ff;
      rs_in      = (pos_ff == '0) ? LW'(item.total_size) : rs_ff;
      pll_in     = pll_ff;
      desc_in    = desc_ff;
      pbs_in     = pbs_ff;
      nh_in      = nh_ff;
      left_in    = left_ff;
      do_walk    = 1'b0;
      result     = '0;
      limit      = LX'(rs_in) - LX'(lorv_pkg::DESC_START) - LX'(pll_ff);
      node_rem   = LX'(rs_in) - LX'(lorv_pkg::DESC_START) - LX'(desc_ff) - pbs_ff;
      node_len   = {item.data_byte, nh_ff[23:16]};
      walk_rem   = '0;
      count      = LX'(pos_ff) + LX'(1);
      off_w      = '0;
      size_w     = '0;

      // size is sampled on the first byte
      if (pos_ff == '0 && LX'(rs_in) < LX'(lorv_pkg::MIN_RECORD)) begin
         verdict_in = lorv_pkg::V_BAD;
         phase_in   = lorv_pkg::PH_DONE;
      end

      if (verdict_in == lorv_pkg::V_PENDING) begin
         case (phase_ff)
            lorv_pkg::PH_HEADER: begin
               if (LX'(pos_ff) == LX'(lorv_pkg::PLL_LO_POS)) begin
                  pll_in = 16'(item.data_byte);
               end else if (LX'(pos_ff) == LX'(lorv_pkg::PLL_HI_POS)) begin
                  pll_in = {item.data_byte, pll_ff[7:0]};
                  if (LX'(pll_in) > LX'(rs_in) - LX'(lorv_pkg::LIST_SLACK)) begin
                     verdict_in = lorv_pkg::V_BAD;
                     phase_in   = lorv_pkg::PH_DONE;
                  end else begin
                     phase_in = lorv_pkg::PH_DESC;
                     desc_in  = '0;
                  end
               end
            end
            lorv_pkg::PH_DESC: begin
               desc_in = desc_ff + LW'(1);
               if (desc_ff[0]) begin
                  // high byte of a ucs-2 character
                  if (item.data_byte != 8'd0) begin
                     verdict_in = lorv_pkg::V_BAD;
                     phase_in   = lorv_pkg::PH_DONE;
                  end
               end else if (item.data_byte == 8'd0) begin
                  if (LX'(desc_in) >= limit) begin
                     verdict_in = lorv_pkg::V_BAD;
                     phase_in   = lorv_pkg::PH_DONE;
                  end else begin
                     phase_in = lorv_pkg::PH_DESC_TERM;
                  end
               end
               if (phase_in == lorv_pkg::PH_DESC && LX'(desc_in) >= limit) begin
                  verdict_in = lorv_pkg::V_BAD;
                  phase_in   = lorv_pkg::PH_DONE;
               end
            end
            lorv_pkg::PH_DESC_TERM: begin
               desc_in = desc_ff + LW'(1);
               if (item.data_byte != 8'd0) begin
                  verdict_in = lorv_pkg::V_BAD;
                  phase_in   = lorv_pkg::PH_DONE;
               end else if (LX'(desc_in) == limit) begin
                  // description fills the rest, path not examined
                  verdict_in = lorv_pkg::V_NOOPT;
                  phase_in   = lorv_pkg::PH_DONE;
               end else begin
                  pbs_in  = '0;
                  do_walk = 1'b1;
               end
            end
            lorv_pkg::PH_NODE_HDR: begin
               if (LX'(left_ff) < LX'(lorv_pkg::HDR_LAST_K)) begin
                  nh_in   = nh_ff | (24'(item.data_byte) << {left_ff[1:0], 3'b000});
                  left_in = left_ff + LW'(1);
               end else if (LX'(node_len) < LX'(lorv_pkg::NODE_MIN) ||
                            LX'(node_len) > node_rem) begin
                  verdict_in = lorv_pkg::V_BAD;
                  phase_in   = lorv_pkg::PH_DONE;
               end else if (nh_ff[7:0] == lorv_pkg::END_TYPE &&
                            nh_ff[15:8] == lorv_pkg::END_SUBTYPE) begin
                  if (LX'(node_len) != LX'(lorv_pkg::NODE_MIN)) begin
                     verdict_in = lorv_pkg::V_BAD;
                  end else begin
                     pbs_in     = pbs_ff + LX'(lorv_pkg::NODE_MIN);
                     verdict_in = (pbs_in == LX'(pll_ff)) ? lorv_pkg::V_OPT
                                                          : lorv_pkg::V_BAD;
                  end
                  phase_in = lorv_pkg::PH_DONE;
               end else begin
                  pbs_in = pbs_ff + LX'(node_len);
                  if (LX'(node_len) == LX'(lorv_pkg::NODE_MIN)) begin
                     do_walk = 1'b1;
                  end else begin
                     phase_in = lorv_pkg::PH_NODE_BODY;
                     left_in  = LW'(LX'(node_len) - LX'(lorv_pkg::NODE_MIN));
                  end
               end
            end
            lorv_pkg::PH_NODE_BODY: begin
               left_in = left_ff - LW'(1);
               if (left_in == '0) begin
                  do_walk = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // next node or end of walk
      if (do_walk) begin
         walk_rem = LX'(rs_in) - LX'(lorv_pkg::DESC_START) - LX'(desc_in) - pbs_in;
         if (walk_rem < LX'(lorv_pkg::NODE_MIN)) begin
            verdict_in = (pbs_in == LX'(pll_in)) ? lorv_pkg::V_OPT : lorv_pkg::V_BAD;
            phase_in   = lorv_pkg::PH_DONE;
         end else begin
            phase_in = lorv_pkg::PH_NODE_HDR;
            nh_in    = '0;
            left_in  = '0;
         end
      end

      if (item.last_byte) begin
         if (count != LX'(rs_in) || verdict_in == lorv_pkg::V_PENDING) begin
            verdict_in = lorv_pkg::V_BAD;
         end
         off_w  = WW'(lorv_pkg::DESC_START) + WW'(desc_in) + WW'(pbs_in);
         size_w = WW'(rs_in) - off_w;
         result.fire = 1'b1;
         case (verdict_in)
            lorv_pkg::V_NOOPT: begin
               result.status = lorv_pkg::ST_NOOPT;
            end
            lorv_pkg::V_OPT: begin
               result.status     = lorv_pkg::ST_OPT;
               result.opt_offset = off_w[15:0];
               result.opt_size   = size_w[15:0];
            end
            default: begin
               result.status = lorv_pkg::ST_BAD;
            end
         endcase
         // back to reset state for the next record
         phase_in   = lorv_pkg::PH_HEADER;
         verdict_in = lorv_pkg::V_PENDING;
         pos_in     = '0;
         rs_in      = '0;
         pll_in     = '0;
         desc_in    = '0;
         pbs_in     = '0;
         nh_in      = '0;
         left_in    = '0;
      end else begin
         if (count >= LX'(rs_in)) begin
            verdict_in = lorv_pkg::V_BAD;
            phase_in   = lorv_pkg::PH_DONE;
         end
         if (pos_ff != {LW{1'b1}}) begin
            pos_in = pos_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lorv_pkg::PH_HEADER;
         verdict_ff <= lorv_pkg::V_PENDING;
         pos_ff     <= '0;
         rs_ff      <= '0;
         pll_ff     <= '0;
         desc_ff    <= '0;
         pbs_ff     <= '0;
         nh_ff      <= '0;
         left_ff    <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         verdict_ff <= verdict_in;
         pos_ff     <= pos_in;
         rs_ff      <= rs_in;
         pll_ff     <= pll_in;
         desc_ff    <= desc_in;
         pbs_ff     <= pbs_in;
         nh_ff      <= nh_in;
         left_ff    <= left_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/load_option_record_validator_top.sv @@
// an accepted byte is held in the input register, and its result in the output register, on the way to the rsp_ side
// throughput: one byte per cycle while req_stall is low, set by the per-byte state update in lorv_parser
// a result waits in the output register while the next record's bytes keep
// flowing, only that record's last byte stalls until the result is taken
// reset: synchronous active high, returns the parser to the record header
// and empties both the input and output registers
// ----------------------------------------------------------------------------
// load_option_record_validator_top
// checks a boot load option record streamed one byte per item and reports
// valid, valid with optional data, or invalid on the record's last byte
// ----------------------------------------------------------------------------
`default_nettype none

module load_option_record_validator_top #(
   parameter int LENGTH_WIDTH = 16
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire  [15:0] req_total_size,
   input  wire         req_last_byte,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_opt_offset,
   output logic [15:0] rsp_opt_size
);

   // input register
   logic               in_valid_ff, in_valid_in;
   lorv_pkg::item_type in_item_ff, in_item_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   lorv_pkg::result_type out_ff, out_in;

   lorv_pkg::result_type step_result;

   logic out_free;
   logic advance;
   logic req_take;

   // output slot is free when empty or being drained this cycle
   assign out_free = !out_valid_ff || !rsp_stall;

   // a byte that makes no result never waits on the output side
   assign advance  = in_valid_ff && (!in_item_ff.last_byte || out_free);

   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in           = 1'b1;
         in_item_in.data_byte  = req_data_byte;
         in_item_in.total_size = req_total_size;
         in_item_in.last_byte  = req_last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance && step_result.fire) begin
         out_valid_in = 1'b1;
         out_in       = step_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // per-byte checks and record state
   lorv_parser #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_ff     <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_opt_offset = out_ff.opt_offset;
   assign rsp_opt_size   = out_ff.opt_size;

endmodule

`default_nettype wire
